FILE: sv/spp_pkg.sv
// Shared types and constants for the stepper step profiler.
// No dependencies; every other file refers to it by scoped names.
package spp_pkg;

	localparam int ANGLE_W      = 32;
	localparam int TIME_W       = 32;
	localparam int STEP_ANGLE_W = 31;
	localparam int COUNT_W      = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;

	// Shared divider: 32-bit divisor and remainder, MSB-first dividend shift register.
	localparam int DIV_W  = 32;
	localparam int DVD_W  = 64;
	localparam int QUO_W  = 36;
	localparam int ITER_W = 6;

	localparam int PROD_W = STEP_ANGLE_W + TIME_W;  // step_angle * elapsed
	localparam int OFF_W  = ANGLE_W + 2;            // saturated angle offset
	localparam int NUM_W  = ANGLE_W + 4;            // rounding numerator
	localparam int ANG_X_W = ANGLE_W + 4;           // extended angle for compare

	localparam logic [ITER_W-1:0] IT_SNAP = ITER_W'(DIV_W);
	localparam logic [ITER_W-1:0] IT_CMD  = ITER_W'(NUM_W);
	localparam logic [ITER_W-1:0] IT_KT   = ITER_W'(TIME_W);
	localparam logic [ITER_W-1:0] IT_OFF  = ITER_W'(OFF_W);

	localparam logic [STEP_ANGLE_W-1:0] STEP_ANGLE_RST = STEP_ANGLE_W'(4685082);
	localparam logic [TIME_W-1:0]       STEP_TIME_RST  = TIME_W'(1000);

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		DIV_SNAP,
		DIV_CMD,
		DIV_KT,
		DIV_OFF
	} spp_divop_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SNAP_WAIT,
		ST_CMD_PREP,
		ST_CMD_GO,
		ST_CMD_WAIT,
		ST_MUL,
		ST_KT_WAIT,
		ST_OFF_GO,
		ST_OFF_WAIT,
		ST_FIN
	} spp_state_t;

	typedef struct packed {
		logic       accept;
		logic       div_start;
		spp_divop_t div_sel;
		logic       snap_take;
		logic       cmd_prep;
		logic       cmd_take;
		logic       mul;
		logic       kt_take;
		logic       off_cap;
		logic       off_take;
		logic       finish;
	} spp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic off_sat;
	} spp_status_t;

endpackage

FILE: sv/spp_item_if.sv
// Input channel of the step profiler: valid/ready plus one request.
// Widths come from spp_pkg.
interface spp_item_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic signed [spp_pkg::ANGLE_W-1:0] desired_angle;

	modport source (output valid, output op, output desired_angle, input ready);
	modport sink (input valid, input op, input desired_angle, output ready);
endinterface

FILE: sv/spp_result_if.sv
// Result channel of the step profiler: valid/ready plus one result.
// Widths come from spp_pkg.
interface spp_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [spp_pkg::COUNT_W-1:0]  steps_commanded;
	logic signed [spp_pkg::COUNT_W-1:0]  step_count;
	logic signed [spp_pkg::ANGLE_W-1:0]  current_angle;
	logic                                motion_done;

	modport source (output valid, output steps_commanded, output step_count,
		output current_angle, output motion_done, input ready);
	modport sink (input valid, input steps_commanded, input step_count,
		input current_angle, input motion_done, output ready);
endinterface

FILE: sv/spp_cfg_if.sv
// Register write channel of the step profiler: valid/ready, index, data.
// Widths come from spp_pkg.
interface spp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [spp_pkg::CFG_IDX_W-1:0]     index;
	logic [spp_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/spp_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on spp_pkg. rem_init must be below the divisor.
module spp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spp_pkg::DIV_W-1:0]     rem_init,
	input  logic [spp_pkg::DVD_W-1:0]     dividend,
	input  logic [spp_pkg::ITER_W-1:0]    iters,
	input  logic [spp_pkg::DIV_W-1:0]     divisor,
	output logic [spp_pkg::QUO_W-1:0]     quotient,
	output logic [spp_pkg::DIV_W-1:0]     remainder,
	output logic                          done
);

	logic                          busy_q;
	logic                          done_q;
	logic [spp_pkg::ITER_W-1:0]    cnt_q;
	logic [spp_pkg::DIV_W-1:0]     rem_q;
	logic [spp_pkg::DVD_W-1:0]     dvd_q;
	logic [spp_pkg::DIV_W-1:0]     dsr_q;
	logic [spp_pkg::QUO_W-1:0]     quo_q;

	logic [spp_pkg::DIV_W:0] rem2;
	logic [spp_pkg::DIV_W:0] diff;
	logic                    ge;

	assign rem2 = {rem_q, dvd_q[spp_pkg::DVD_W-1]};
	assign diff = rem2 - {1'b0, dsr_q};
	assign ge   = rem2 >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == spp_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits always fit
			rem_q <= ge ? diff[spp_pkg::DIV_W-1:0] : rem2[spp_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[spp_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[spp_pkg::QUO_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

FILE: sv/spp_dp.sv
// Datapath: registers, motion state, snapping/rounding, offset math, result register.
// Depends on spp_pkg, spp_div and the controller's command struct.
module spp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spp_pkg::spp_cmd_t                   cmd,
	output spp_pkg::spp_status_t                status,
	input  logic                                cfg_we,
	input  logic [spp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                item_op,
	input  logic [spp_pkg::ANGLE_W-1:0]         item_angle,
	output logic [spp_pkg::COUNT_W-1:0]         res_cmd,
	output logic [spp_pkg::COUNT_W-1:0]         res_count,
	output logic [spp_pkg::ANGLE_W-1:0]         res_angle,
	output logic                                res_done
);

	localparam int AW = spp_pkg::ANGLE_W;
	localparam int SW = spp_pkg::STEP_ANGLE_W;
	localparam int TW = spp_pkg::TIME_W;
	localparam int CW = spp_pkg::COUNT_W;
	localparam int NW = spp_pkg::NUM_W;
	localparam int XW = spp_pkg::ANG_X_W;
	localparam int OW = spp_pkg::OFF_W;
	localparam int PW = spp_pkg::PROD_W;
	localparam int QW = spp_pkg::QUO_W;
	localparam int DW = spp_pkg::DIV_W;
	localparam int VW = spp_pkg::DVD_W;

	localparam logic [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};

	// configuration
	logic [SW-1:0] sa_q;
	logic [TW-1:0] st_q;
	logic [SW-1:0] sa_eff;
	logic [TW-1:0] st_eff;

	// motion state
	logic          op_q;
	logic [AW-1:0] desired_q;
	logic [TW-1:0] elapsed_q;
	logic [AW-1:0] target_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] present_q;
	logic [CW-1:0] cmdsteps_q;
	logic [TW-1:0] q_q;
	logic [OW-1:0] off_q;
	logic [PW-1:0] prod_q;
	logic [NW-1:0] a_q;
	logic          neg_q;

	// result register
	logic [CW-1:0] res_cmd_q;
	logic [CW-1:0] res_count_q;
	logic [AW-1:0] res_angle_q;
	logic          res_done_q;

	// divider
	logic [DW-1:0]            div_rem0;
	logic [VW-1:0]            div_dvd;
	logic [spp_pkg::ITER_W-1:0] div_it;
	logic [DW-1:0]            div_dsr;
	logic [QW-1:0]            div_quo;
	logic [DW-1:0]            div_rem;
	logic                     div_done;

	assign sa_eff = (sa_q == '0) ? SW'(1) : sa_q;
	assign st_eff = (st_q == '0) ? TW'(1) : st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q <= spp_pkg::STEP_ANGLE_RST;
			st_q <= spp_pkg::STEP_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spp_pkg::CFG_STEP_ANGLE: sa_q <= cfg_data[SW-1:0];
				spp_pkg::CFG_STEP_TIME:  st_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// snap: magnitude of the present angle, rounded away to the step grid
	logic          p_neg;
	logic [AW-1:0] m;
	logic [AW:0]   mag;
	logic [AW-1:0] snapped;

	assign p_neg = present_q[AW-1] || (present_q == '0);
	assign m     = p_neg ? (AW'(0) - present_q) : present_q;
	assign mag   = (div_rem == '0) ? {1'b0, m}
		: ({1'b0, m} + (AW+1)'(sa_eff) - (AW+1)'(div_rem));

	always_comb begin
		if (p_neg) begin
			if (mag > {1'b0, ANG_MIN}) snapped = ANG_MIN;
			else                       snapped = AW'((AW+1)'(0) - mag);
		end else begin
			if (mag > {1'b0, ANG_MAX}) snapped = ANG_MAX;
			else                       snapped = mag[AW-1:0];
		end
	end

	// rounding numerator 2*delta + s; negative side uses ceil to get floor
	logic signed [NW-1:0] delta;
	logic signed [NW-1:0] num;
	logic        [NW-1:0] abs_num;
	logic        [NW-1:0] a_next;

	assign delta   = NW'($signed(target_q)) - NW'($signed(start_q));
	assign num     = (delta <<< 1) + $signed(NW'(sa_eff));
	assign abs_num = num[NW-1] ? NW'(-num) : NW'(num);
	assign a_next  = num[NW-1] ? (abs_num + NW'({sa_eff, 1'b0}) - NW'(1)) : abs_num;

	// commanded step count from the rounding quotient, saturated
	logic [CW-1:0] cmd_sat;
	always_comb begin
		if (neg_q) begin
			if (div_quo > QW'(CNT_MIN)) cmd_sat = CNT_MIN;
			else                        cmd_sat = CW'(0) - div_quo[CW-1:0];
		end else begin
			if (div_quo > QW'(CNT_MAX)) cmd_sat = CNT_MAX;
			else                        cmd_sat = div_quo[CW-1:0];
		end
	end

	logic [PW-DW-2-1:0] prod_hi;
	assign prod_hi = prod_q[PW-1:OW];
	assign status.off_sat  = DW'(prod_hi) >= st_eff;
	assign status.div_done = div_done;

	always_comb begin
		unique case (cmd.div_sel)
			spp_pkg::DIV_SNAP: begin
				div_rem0 = '0;
				div_dvd  = {m, (VW-AW)'(0)};
				div_it   = spp_pkg::IT_SNAP;
				div_dsr  = DW'(sa_eff);
			end
			spp_pkg::DIV_CMD: begin
				div_rem0 = '0;
				div_dvd  = {a_q, (VW-NW)'(0)};
				div_it   = spp_pkg::IT_CMD;
				div_dsr  = DW'({sa_eff, 1'b0});
			end
			spp_pkg::DIV_KT: begin
				div_rem0 = '0;
				div_dvd  = {elapsed_q, (VW-TW)'(0)};
				div_it   = spp_pkg::IT_KT;
				div_dsr  = DW'(st_eff);
			end
			spp_pkg::DIV_OFF: begin
				div_rem0 = DW'(prod_hi);
				div_dvd  = {prod_q[OW-1:0], (VW-OW)'(0)};
				div_it   = spp_pkg::IT_OFF;
				div_dsr  = DW'(st_eff);
			end
			default: begin
				div_rem0 = '0;
				div_dvd  = '0;
				div_it   = '0;
				div_dsr  = DW'(1);
			end
		endcase
	end

	spp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.rem_init  (div_rem0),
		.dividend  (div_dvd),
		.iters     (div_it),
		.divisor   (div_dsr),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	// interpolated angle and completion
	logic signed [XW-1:0] ang;
	logic signed [XW-1:0] tgt_x;
	logic                 up;
	logic                 fin_done;
	logic [CW-1:0]        taken;

	assign up    = $signed(cmdsteps_q) > $signed(CW'(0));
	assign tgt_x = XW'($signed(target_q));
	assign ang   = up ? (XW'($signed(start_q)) + $signed(XW'(off_q)))
		: (XW'($signed(start_q)) - $signed(XW'(off_q)));
	assign fin_done = up ? (ang >= tgt_x) : (ang <= tgt_x);

	always_comb begin
		if (fin_done) begin
			taken = cmdsteps_q;
		end else if (up) begin
			taken = (q_q > TW'(CNT_MAX)) ? CNT_MAX : CW'(q_q);
		end else begin
			taken = (q_q > TW'(CNT_MIN)) ? CNT_MIN : (CW'(0) - CW'(q_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			target_q   <= '0;
			start_q    <= '0;
			present_q  <= '0;
			cmdsteps_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (item_op)                elapsed_q <= '0;
				else if (elapsed_q != '1)   elapsed_q <= elapsed_q + 1'b1;
			end
			if (cmd.snap_take) begin
				start_q  <= snapped;
				target_q <= desired_q;
			end
			if (cmd.cmd_take) cmdsteps_q <= cmd_sat;
			if (cmd.finish)   present_q  <= fin_done ? target_q : ang[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= item_op;
			desired_q <= item_angle;
		end
		if (cmd.cmd_prep) begin
			a_q   <= a_next;
			neg_q <= num[NW-1];
		end
		// a fresh target starts at zero elapsed: no offset, no whole steps
		if (cmd.cmd_take) begin
			q_q   <= '0;
			off_q <= '0;
		end
		if (cmd.mul)      prod_q <= PW'(sa_eff) * PW'(elapsed_q);
		if (cmd.kt_take)  q_q    <= div_quo[TW-1:0];
		if (cmd.off_cap)  off_q  <= '1;
		if (cmd.off_take) off_q  <= div_quo[OW-1:0];
		if (cmd.finish) begin
			res_cmd_q   <= op_q ? cmdsteps_q : '0;
			res_count_q <= taken;
			res_angle_q <= fin_done ? target_q : ang[AW-1:0];
			res_done_q  <= fin_done;
		end
	end

	assign res_cmd   = res_cmd_q;
	assign res_count = res_count_q;
	assign res_angle = res_angle_q;
	assign res_done  = res_done_q;

endmodule

FILE: sv/spp_ctrl.sv
// Controller: sequences one request through the shared divider and owns the handshakes.
// Depends on spp_pkg; drives spp_dp through the command struct.
module spp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_op,
	output logic                  item_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  spp_pkg::spp_status_t  status,
	output spp_pkg::spp_cmd_t     cmd
);

	spp_pkg::spp_state_t state_q;
	spp_pkg::spp_state_t state_nxt;
	logic                valid_q;
	logic                take;
	logic                slot_free;

	assign take      = item_valid && (state_q == spp_pkg::ST_IDLE);
	assign slot_free = !valid_q || result_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spp_pkg::ST_IDLE:
				if (take) state_nxt = item_op ? spp_pkg::ST_SNAP_WAIT : spp_pkg::ST_MUL;
			spp_pkg::ST_SNAP_WAIT:
				if (status.div_done) state_nxt = spp_pkg::ST_CMD_PREP;
			spp_pkg::ST_CMD_PREP: state_nxt = spp_pkg::ST_CMD_GO;
			spp_pkg::ST_CMD_GO:   state_nxt = spp_pkg::ST_CMD_WAIT;
			spp_pkg::ST_CMD_WAIT:
				if (status.div_done) state_nxt = spp_pkg::ST_FIN;
			spp_pkg::ST_MUL:      state_nxt = spp_pkg::ST_KT_WAIT;
			spp_pkg::ST_KT_WAIT:
				if (status.div_done) state_nxt = spp_pkg::ST_OFF_GO;
			spp_pkg::ST_OFF_GO:
				state_nxt = status.off_sat ? spp_pkg::ST_FIN : spp_pkg::ST_OFF_WAIT;
			spp_pkg::ST_OFF_WAIT:
				if (status.div_done) state_nxt = spp_pkg::ST_FIN;
			spp_pkg::ST_FIN:
				if (slot_free) state_nxt = spp_pkg::ST_IDLE;
			default: state_nxt = spp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.div_sel   = spp_pkg::DIV_SNAP;
		unique case (state_q)
			spp_pkg::ST_IDLE: begin
				cmd.accept    = take;
				cmd.div_start = take && item_op;
			end
			spp_pkg::ST_SNAP_WAIT: cmd.snap_take = status.div_done;
			spp_pkg::ST_CMD_PREP:  cmd.cmd_prep  = 1'b1;
			spp_pkg::ST_CMD_GO: begin
				cmd.div_sel   = spp_pkg::DIV_CMD;
				cmd.div_start = 1'b1;
			end
			spp_pkg::ST_CMD_WAIT:  cmd.cmd_take = status.div_done;
			spp_pkg::ST_MUL: begin
				// product and whole-step division read only elapsed and the registers, not each other
				cmd.mul       = 1'b1;
				cmd.div_sel   = spp_pkg::DIV_KT;
				cmd.div_start = 1'b1;
			end
			spp_pkg::ST_KT_WAIT:   cmd.kt_take = status.div_done;
			spp_pkg::ST_OFF_GO: begin
				cmd.div_sel   = spp_pkg::DIV_OFF;
				cmd.off_cap   = status.off_sat;
				cmd.div_start = !status.off_sat;
			end
			spp_pkg::ST_OFF_WAIT:  cmd.off_take = status.div_done;
			spp_pkg::ST_FIN:       cmd.finish   = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spp_pkg::ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish)        valid_q <= 1'b1;
			else if (result_ready) valid_q <= 1'b0;
		end
	end

	assign item_ready   = (state_q == spp_pkg::ST_IDLE);
	assign result_valid = valid_q;

endmodule

FILE: sv/stepper_step_profiler_core.sv
// Stepper step profiler top level. One request at a time through a shared 1-bit/cycle divider.
// A new target runs the snap division, then the rounding division; a tick runs the whole-step
// division, then the offset division, which is skipped when the offset saturates.
// The next request starts while a result waits for the receiver.
// Reset (arst_n low): registers return to 4685082 / 1000, the start, target and present angle,
// elapsed time and commanded steps clear, and the channels go idle.
module stepper_step_profiler_core (
	input  logic        clk,
	input  logic        arst_n,
	spp_item_if.sink    item,
	spp_result_if.source result,
	spp_cfg_if.sink     cfg
);

	spp_pkg::spp_cmd_t    cmd;
	spp_pkg::spp_status_t status;

	logic [spp_pkg::COUNT_W-1:0] res_cmd;
	logic [spp_pkg::COUNT_W-1:0] res_count;
	logic [spp_pkg::ANGLE_W-1:0] res_angle;
	logic                        res_done;

	assign cfg.ready = 1'b1;

	spp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_op      (item.op),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	spp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.item_op    (item.op),
		.item_angle (item.desired_angle),
		.res_cmd    (res_cmd),
		.res_count  (res_count),
		.res_angle  (res_angle),
		.res_done   (res_done)
	);

	assign result.steps_commanded = res_cmd;
	assign result.step_count      = res_count;
	assign result.current_angle   = res_angle;
	assign result.motion_done     = res_done;

endmodule

FILE: verif/spp_profile_checker.sv
`timescale 1ns / 1ps
// Result checker for the stepper step profiler: follows the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on spp_pkg and the spp_item_if, spp_result_if and spp_cfg_if interfaces.
module spp_profile_checker (
	input  logic  clk,
	input  logic  arst_n,
	spp_item_if   item,
	spp_result_if result,
	spp_cfg_if    cfg,
	output int    mismatches,
	output int    pending
);
	localparam logic OP_TARGET = 1'b1;

	localparam longint ANG_HI = 64'sd2147483647;
	localparam longint ANG_LO = -64'sd2147483648;
	localparam longint CNT_HI = 64'sd2147483647;
	localparam longint CNT_LO = -64'sd2147483648;
	localparam longint unsigned TICKS_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam longint unsigned OFF_CAP   = 64'h4000_0000_0000_0000;

	typedef struct {
		logic [spp_pkg::COUNT_W-1:0] steps_commanded;
		logic [spp_pkg::COUNT_W-1:0] step_count;
		logic [spp_pkg::ANGLE_W-1:0] current_angle;
		logic                        motion_done;
	} motion_result_t;

	motion_result_t expected_motion[$];
	int fail_total = 0;
	int queued_cnt = 0;

	// Shadow of the register file
	logic [spp_pkg::STEP_ANGLE_W-1:0] step_angle_q;
	logic [spp_pkg::TIME_W-1:0]       step_time_q;

	// Shadow of the motion state
	longint          tgt_angle;
	longint          from_angle;
	longint          now_angle;
	longint          cmd_steps;
	longint          done_steps;
	longint unsigned ticks_elapsed;

	assign mismatches = fail_total;
	assign pending    = queued_cnt;

	task automatic report_mismatch(input string note);
		$display("ERROR %0t: %s", $time, note);
		fail_total++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got),
				$signed(want)));
	endtask

	function automatic longint floor_quot(input longint a, input longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp_range(input longint v, input longint lo,
		input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic motion_result_t predict_motion(input logic op,
		input logic signed [31:0] desired);
		motion_result_t  r;
		longint          s, snapped, delta, shown, ang;
		longint unsigned sa, st, q, rem, off;
		bit              done;
		sa = (step_angle_q == 0) ? 64'd1 : 64'(step_angle_q);
		st = (step_time_q == 0) ? 64'd1 : 64'(step_time_q);
		s = longint'(sa);
		shown = 0;
		if (op == OP_TARGET) begin
			// snap away from zero on the positive side, toward minus infinity otherwise
			if (now_angle > 0)
				snapped = -floor_quot(-now_angle, s) * s;
			else
				snapped = floor_quot(now_angle, s) * s;
			snapped = clamp_range(snapped, ANG_LO, ANG_HI);
			tgt_angle = longint'(desired);
			from_angle = snapped;
			delta = tgt_angle - snapped;
			cmd_steps = clamp_range(floor_quot(2 * delta + s, 2 * s), CNT_LO, CNT_HI);
			ticks_elapsed = 0;
			shown = cmd_steps;
		end else if (ticks_elapsed < TICKS_MAX) begin
			ticks_elapsed++;
		end
		q = ticks_elapsed / st;
		rem = ticks_elapsed % st;
		if (q >= 64'h1_0000_0000) begin
			off = OFF_CAP;
		end else begin
			off = sa * q + (sa * rem) / st;
			if (off > OFF_CAP)
				off = OFF_CAP;
		end
		if (cmd_steps > 0) begin
			ang = from_angle + longint'(off);
			done = (ang >= tgt_angle);
			done_steps = (q > 64'd2147483647) ? CNT_HI : longint'(q);
		end else begin
			// zero commanded steps moves downward too
			ang = from_angle - longint'(off);
			done = (ang <= tgt_angle);
			done_steps = (q > 64'd2147483648) ? CNT_LO : -longint'(q);
		end
		if (done) begin
			done_steps = cmd_steps;
			now_angle = tgt_angle;
		end else begin
			now_angle = ang;
		end
		r.steps_commanded = shown[31:0];
		r.step_count = done_steps[31:0];
		r.current_angle = now_angle[31:0];
		r.motion_done = done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		motion_result_t want;
		if (!arst_n) begin
			step_angle_q = spp_pkg::STEP_ANGLE_RST;
			step_time_q = spp_pkg::STEP_TIME_RST;
			tgt_angle = 0;
			from_angle = 0;
			now_angle = 0;
			cmd_steps = 0;
			done_steps = 0;
			ticks_elapsed = 0;
			expected_motion.delete();
			queued_cnt <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_motion.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_motion.pop_front();
					check_field("steps_commanded", result.steps_commanded,
						want.steps_commanded);
					check_field("step_count", result.step_count, want.step_count);
					check_field("current_angle", result.current_angle, want.current_angle);
					check_field("motion_done", 32'(result.motion_done),
						32'(want.motion_done));
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == spp_pkg::CFG_STEP_ANGLE)
					step_angle_q = cfg.data[spp_pkg::STEP_ANGLE_W-1:0];
				else if (cfg.index == spp_pkg::CFG_STEP_TIME)
					step_time_q = cfg.data;
			end
			if (item.valid && item.ready)
				expected_motion.push_back(predict_motion(item.op, item.desired_angle));
			queued_cnt <= expected_motion.size();
		end
	end
endmodule

FILE: verif/tb_stepper_step_profiler_core.sv
`timescale 1ns / 1ps
// Top of the stepper step profiler testbench: clock, reset, request and register
// stimulus, receiver stalls and the verdict. Checking lives in spp_profile_checker.
// Depends on spp_pkg, the channel interfaces and stepper_step_profiler_core.
module tb_stepper_step_profiler_core;
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_TARGET = 1'b1;

	localparam longint ANG_HI = 64'sd2147483647;
	localparam longint ANG_LO = -64'sd2147483648;
	localparam longint RST_SA = longint'(spp_pkg::STEP_ANGLE_RST);

	logic clk;
	logic arst_n;

	spp_item_if   item_ch ();
	spp_result_if result_ch ();
	spp_cfg_if    cfg_ch ();

	int mismatches;
	int pending;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// What the stimulus knows of the block, used to aim targets near reach
	longint                           last_target = 0;
	logic [spp_pkg::STEP_ANGLE_W-1:0] cur_sa = spp_pkg::STEP_ANGLE_RST;
	logic [spp_pkg::TIME_W-1:0]       cur_st = spp_pkg::STEP_TIME_RST;

	stepper_step_profiler_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	spp_profile_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_request(input logic op, input logic [31:0] angle);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.op = op;
		item_ch.desired_angle = angle;
		do
			@(posedge clk);
		while (!item_ch.ready);
		if (op == OP_TARGET)
			last_target = longint'($signed(angle));
	endtask

	task automatic run_ticks(input int n);
		repeat (n)
			push_request(OP_TICK, $urandom());
	endtask

	// hold requests back until every result is in
	task automatic drain_requests;
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [spp_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		if (idx == spp_pkg::CFG_STEP_ANGLE)
			cur_sa = value[spp_pkg::STEP_ANGLE_W-1:0];
		else
			cur_st = value;
	endtask

	task automatic set_profile(input logic [31:0] sa, input logic [31:0] st);
		drain_requests();
		write_reg(spp_pkg::CFG_STEP_ANGLE, sa);
		write_reg(spp_pkg::CFG_STEP_TIME, st);
	endtask

	// target about k steps from the last one, with some off-grid jitter
	function automatic logic [31:0] near_target(input int k);
		longint unsigned sa_eff;
		longint          span, jitter, t;
		sa_eff = (cur_sa == 0) ? 64'd1 : 64'(cur_sa);
		span = longint'(sa_eff) * k;
		jitter = longint'($urandom_range(0, 32'(sa_eff))) - longint'(sa_eff / 2);
		if ($urandom_range(1))
			t = last_target + span + jitter;
		else
			t = last_target - span + jitter;
		if (t > ANG_HI)
			t = ANG_HI;
		if (t < ANG_LO)
			t = ANG_LO;
		return t[31:0];
	endfunction

	initial begin
		int          blk, roll, k, sent;
		longint      n, st_eff;
		logic [31:0] sa_val, st_val;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_TICK;
		item_ch.desired_angle = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = spp_pkg::CFG_STEP_ANGLE;
		cfg_ch.data = '0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ties in both directions, tick before any target, zero move
		set_profile(32'(RST_SA), 32'd1);
		push_request(OP_TICK, 32'h7FFF_FFFF);
		push_request(OP_TARGET, 32'd0);
		push_request(OP_TARGET, 32'(RST_SA * 5 / 2));
		run_ticks(3);
		push_request(OP_TARGET, 32'(-RST_SA * 3 / 2));
		run_ticks(5);
		// zero step angle and time, saturated commanded counts
		set_profile(32'd0, 32'd0);
		push_request(OP_TARGET, 32'h7FFF_FFFF);
		run_ticks(1);
		push_request(OP_TARGET, 32'h8000_0000);
		run_ticks(1);
		// coarse grid: snapped angle clamps at both ends
		set_profile(32'h4000_0001, 32'd1);
		push_request(OP_TARGET, 32'h7FFF_FFFF);
		run_ticks(3);
		push_request(OP_TARGET, 32'h8000_0000);
		run_ticks(4);
		push_request(OP_TARGET, 32'sd100);

		for (blk = 0; blk < 8; blk++) begin
			case (blk % 6)
				0: sa_val = 32'd0;
				1: sa_val = 32'd1;
				2: sa_val = 32'hFFFF_FFFF;
				3: sa_val = 32'(RST_SA);
				4: sa_val = $urandom_range(1, 1 << 20);
				default: sa_val = $urandom();
			endcase
			case ((blk + 3) % 5)
				0: st_val = 32'd0;
				1: st_val = 32'd1;
				2: st_val = 32'hFFFF_FFFF;
				3: st_val = $urandom_range(2, 6);
				default: st_val = $urandom_range(1, 3);
			endcase
			set_profile(sa_val, st_val);
			case (blk % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 84;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 84;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct = 17;
				end
			endcase
			st_eff = (cur_st == 0) ? 64'sd1 : longint'(cur_st);
			sent = 0;
			while (sent < 125) begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					// a move to a reachable target, sometimes cut short by the next one
					k = $urandom_range(0, 12);
					push_request(OP_TARGET, near_target(k));
					n = st_eff * k + $urandom_range(0, 3);
					if (n > 40)
						n = 40;
					if ($urandom_range(3) == 0)
						n = $urandom_range(0, 32'(n));
					run_ticks(int'(n));
					sent += 1 + int'(n);
				end else if (roll < 85) begin
					n = $urandom_range(0, 5);
					push_request(OP_TARGET, $urandom());
					run_ticks(int'(n));
					sent += 1 + int'(n);
				end else begin
					n = $urandom_range(1, 8);
					run_ticks(int'(n));
					sent += int'(n);
				end
			end
		end

		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
